### rtl/core/multi_queue_ring_fifo_macros.svh
// ----------------------------------------------------------------------------
// multi queue ring fifo assertion macros
// shared property shapes for the checks in the rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_RING_FIFO_MACROS_SVH
`define MULTI_QUEUE_RING_FIFO_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define MQRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mqrf check failed");

// next-cycle implication, off while reset is asserted
`define MQRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
		else $error("mqrf check failed");

`endif

### rtl/core/mqrf_pkg.sv
// ----------------------------------------------------------------------------
// mqrf_pkg
// types, sizes and helpers shared by the multi queue ring fifo
// ----------------------------------------------------------------------------
package mqrf_pkg;

	localparam int QUEUE_COUNT = 4;
	localparam int QUEUE_DEPTH = 16;

	localparam int REQ_IDX_W = 4;
	localparam int IDX_EXT_W = REQ_IDX_W + 1;
	localparam int WORD_W    = 32;
	localparam int OCC_W     = 5;
	localparam int QIDX_W    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int STORE_AW  = $clog2(STORE_DEPTH);

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PUSH  = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// per-queue bookkeeping word held in the meta ram
	typedef struct packed {
		logic [WORD_W-1:0] lost;
		logic [CNT_W-1:0]  fill;
		logic [PTR_W-1:0]  wp;
		logic [PTR_W-1:0]  rp;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	// outcome of one transaction against its queue
	typedef struct packed {
		status_t status;
		logic    pop_ok;
		logic    push_ok;
	} upd_t;

	function automatic logic [STORE_AW-1:0] word_addr(
		input logic [QIDX_W-1:0] q,
		input logic [PTR_W-1:0]  ptr
	);
		word_addr = STORE_AW'(q) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(ptr);
	endfunction

endpackage

### rtl/core/mqrf_ram.sv
// ----------------------------------------------------------------------------
// mqrf_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mqrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/mqrf_meta_update.sv
// ----------------------------------------------------------------------------
// mqrf_meta_update
// read-modify step for one queue's pointers, fill and lost counter
// ----------------------------------------------------------------------------
module mqrf_meta_update (
	input  mqrf_pkg::meta_t  meta_cur,
	input  logic [1:0]       req_type,
	input  logic             bad,
	output mqrf_pkg::meta_t  meta_nxt,
	output mqrf_pkg::upd_t   upd
);

	function automatic logic [mqrf_pkg::PTR_W-1:0] advance(
		input logic [mqrf_pkg::PTR_W-1:0] p
	);
		advance = (p == mqrf_pkg::PTR_W'(mqrf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		meta_nxt    = meta_cur;
		upd.status  = mqrf_pkg::ST_OK;
		upd.pop_ok  = 1'b0;
		upd.push_ok = 1'b0;
		if (bad) begin
			upd.status = mqrf_pkg::ST_BAD_INDEX;
		end else begin
			case (req_type)
				mqrf_pkg::REQ_CLEAR: begin
					meta_nxt = '0;
				end
				mqrf_pkg::REQ_POP: begin
					if (meta_cur.fill == '0) begin
						upd.status = mqrf_pkg::ST_EMPTY;
					end else begin
						upd.pop_ok    = 1'b1;
						meta_nxt.rp   = advance(meta_cur.rp);
						meta_nxt.fill = meta_cur.fill - 1'b1;
					end
				end
				mqrf_pkg::REQ_PUSH: begin
					if (meta_cur.fill >= mqrf_pkg::CNT_W'(mqrf_pkg::QUEUE_DEPTH)) begin
						upd.status = mqrf_pkg::ST_FULL;
						// saturate at all ones
						if (meta_cur.lost != '1) begin
							meta_nxt.lost = meta_cur.lost + 1'b1;
						end
					end else begin
						upd.push_ok   = 1'b1;
						meta_nxt.wp   = advance(meta_cur.wp);
						meta_nxt.fill = meta_cur.fill + 1'b1;
					end
				end
				default: begin
					// unused request code: no change, plain status
				end
			endcase
		end
	end

endmodule

### rtl/core/multi_queue_ring_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo
// bank of independent ring fifos of 32-bit words behind one request port
// ----------------------------------------------------------------------------
// usage:
//   a request transaction (req_type, queue_index, write_data) is taken at a
//   rising edge where start is high and busy is low. each request gives one
//   result transaction (status, read_data, occupancy, lost_count), shown for
//   exactly one cycle with done high.
//   done follows the accepting edge through the stage 1 and stage 2 registers.
//   no request is taken while one is in flight; busy covers the meta ram
//   read, the read-modify-write of that entry and the word ram read, so a
//   request never sees a stale queue entry.
//   requests: clear empties a queue and zeroes its lost counter, pop returns
//   the oldest word or status empty, push appends or drops the word on a
//   full queue and bumps the saturating lost counter. an index at or above
//   the queue count answers status bad index with all other fields zero.
//   reset: arst_n clears the pipeline and the per-queue valid bits, so every
//   queue reads as empty with a zero lost counter; no clearing pass is run.
//   the receiver cannot stall: results must be taken in their done cycle.
// ----------------------------------------------------------------------------
`include "multi_queue_ring_fifo_macros.svh"

module multi_queue_ring_fifo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [3:0]  queue_index,
	input  logic [31:0] write_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] read_data,
	output logic [4:0]  occupancy,
	output logic [31:0] lost_count
);

	// accept and bad index check
	logic accept;
	logic bad_in;

	// stage 1: meta entry read back, modify, write back
	logic                              valid_s1;
	logic [1:0]                        type_s1;
	logic [mqrf_pkg::QIDX_W-1:0]       q_s1;
	logic [mqrf_pkg::WORD_W-1:0]       data_s1;
	logic                              bad_s1;
	logic                              meta_vld_s1;

	// stage 2: result registers, popped word arrives from the word ram
	logic                              valid_s2;
	mqrf_pkg::status_t                 status_s2;
	logic                              pop_ok_s2;
	logic [mqrf_pkg::OCC_W-1:0]        occ_s2;
	logic [mqrf_pkg::WORD_W-1:0]       lost_s2;

	// valid bits of the meta ram, an invalid entry reads as all zero
	logic [mqrf_pkg::QUEUE_COUNT-1:0]  meta_valid_q;

	logic [mqrf_pkg::META_W-1:0]       meta_rdata;
	mqrf_pkg::meta_t                   meta_cur;
	mqrf_pkg::meta_t                   meta_nxt;
	mqrf_pkg::upd_t                    upd;
	logic                              meta_we;

	logic                              word_we;
	logic [mqrf_pkg::STORE_AW-1:0]     word_waddr;
	logic [mqrf_pkg::STORE_AW-1:0]     word_raddr;
	logic [mqrf_pkg::WORD_W-1:0]       word_rdata;

	assign busy   = valid_s1 | valid_s2;
	assign accept = start & ~busy;
	assign bad_in = mqrf_pkg::IDX_EXT_W'(queue_index) >=
		mqrf_pkg::IDX_EXT_W'(mqrf_pkg::QUEUE_COUNT);

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			meta_valid_q <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (meta_we) begin
				meta_valid_q[q_s1] <= 1'b1;
			end
		end
	end

	// request payload, captured on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1     <= req_type;
			q_s1        <= queue_index[mqrf_pkg::QIDX_W-1:0];
			data_s1     <= write_data;
			bad_s1      <= bad_in;
			meta_vld_s1 <= bad_in ? 1'b0 : meta_valid_q[queue_index[mqrf_pkg::QIDX_W-1:0]];
		end
	end

	// per-queue bookkeeping memory, read at accept, written back in stage 1
	mqrf_ram #(
		.WIDTH (mqrf_pkg::META_W),
		.DEPTH (mqrf_pkg::QUEUE_COUNT)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (q_s1),
		.wdata (meta_nxt),
		.raddr (queue_index[mqrf_pkg::QIDX_W-1:0]),
		.rdata (meta_rdata)
	);

	assign meta_cur = meta_vld_s1 ? mqrf_pkg::meta_t'(meta_rdata) : '0;
	assign meta_we  = valid_s1 & ~bad_s1;

	mqrf_meta_update u_update (
		.meta_cur (meta_cur),
		.req_type (type_s1),
		.bad      (bad_s1),
		.meta_nxt (meta_nxt),
		.upd      (upd)
	);

	// word store: push writes at the write pointer, pop reads at the read pointer
	assign word_we    = valid_s1 & upd.push_ok;
	assign word_waddr = mqrf_pkg::word_addr(q_s1, meta_cur.wp);
	assign word_raddr = mqrf_pkg::word_addr(q_s1, meta_cur.rp);

	mqrf_ram #(
		.WIDTH (mqrf_pkg::WORD_W),
		.DEPTH (mqrf_pkg::STORE_DEPTH)
	) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (data_s1),
		.raddr (word_raddr),
		.rdata (word_rdata)
	);

	// result fields other than status, zeroed on a bad index
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= upd.status;
			pop_ok_s2 <= upd.pop_ok;
			occ_s2    <= bad_s1 ? '0 : mqrf_pkg::OCC_W'(meta_nxt.fill);
			lost_s2   <= bad_s1 ? '0 : meta_nxt.lost;
		end
	end

	assign done       = valid_s2;
	assign status     = status_s2;
	assign read_data  = pop_ok_s2 ? word_rdata : '0;
	assign occupancy  = occ_s2;
	assign lost_count = lost_s2;

	// every accepted request is answered with done
	`MQRF_ASSERT_NEXT(a_accept_done, clk, arst_n, accept, ##1 done)
	// only one request in flight
	`MQRF_ASSERT_IMPL(a_one_in_flight, clk, arst_n, valid_s1, !valid_s2)
	// fill never passes the queue depth
	`MQRF_ASSERT_IMPL(a_fill_bound, clk, arst_n, meta_we,
		meta_nxt.fill <= mqrf_pkg::CNT_W'(mqrf_pkg::QUEUE_DEPTH))
	// bad index answers with all fields zero
	`MQRF_ASSERT_IMPL(a_bad_zero, clk, arst_n, done && status == mqrf_pkg::ST_BAD_INDEX,
		read_data == '0 && occupancy == '0 && lost_count == '0)
	// only a successful pop returns a word
	`MQRF_ASSERT_IMPL(a_rdata_zero, clk, arst_n, done && status != mqrf_pkg::ST_OK,
		read_data == '0)

endmodule
